// File: src/mau_pkg.sv
// mau_pkg: shared types, register map and midpoint arithmetic for the
// midpoint audio upsampler
// no dependencies
package mau_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_RATE_LOG2 = 1'b0,
    REG_STEREO    = 1'b1
  } reg_idx_t;

  localparam logic [1:0] RATE_LOG2_RST = 2'd0;
  localparam logic       STEREO_RST    = 1'b1;

  typedef struct packed {
    logic [1:0] rate_log2;
    logic       stereo;
  } cfg_t;

  // (a+b)/2 truncated toward zero
  function automatic sample_t half_sum(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W:0] s;
    begin
      s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      s = s + {{SAMPLE_W{1'b0}}, s[SAMPLE_W]};
      return s[SAMPLE_W:1];
    end
  endfunction

endpackage

// File: src/midpoint_audio_upsampler_top.sv
// midpoint_audio_upsampler_top: x1/x2/x4/x8 midpoint upsampler, one output
// frame per cycle while out_stall is low; depends on mau_pkg, mau_cfg_regs, mau_point
//
//  port group   direction  handshake              payload
//  in_*         input      in_valid / in_stall    in_prime, in_left_in, in_right_in
//  out_*        output     out_valid / out_stall  out_left_out, out_right_out, out_last
//  apb          input      psel, penable, pready  paddr, pwdata, prdata
//
// an accepted sample item produces 2**rate_log2 output frames, one per cycle
// from the output register while out_stall is low; the run length
// is set by the single job register feeding the point logic
// a prime item only updates the held previous frame and produces nothing
// the next item is taken in the cycle the current run's last frame loads
// reset (synchronous, active low) clears the job, the output register and
// the held previous frame; out_stall holds the output register and the job
module midpoint_audio_upsampler_top #(
  parameter int MAX_RATE_LOG2 = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_prime,
  input  logic signed [15:0]           in_left_in,
  input  logic signed [15:0]           in_right_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           out_left_out,
  output logic signed [15:0]           out_right_out,
  output logic                         out_last,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mau_pkg::PADDR_W-1:0]  paddr,
  input  logic [mau_pkg::PDATA_W-1:0]  pwdata,
  output logic [mau_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int LGW = $clog2(MAX_RATE_LOG2 + 1);
  localparam int CW  = MAX_RATE_LOG2;

  mau_pkg::cfg_t cfg;

  // held previous frame
  logic             have_prev_r;
  mau_pkg::sample_t prev_left_r;
  mau_pkg::sample_t prev_right_r;

  // job register: end points of the current run and the frame counter
  logic             job_valid_r;
  mau_pkg::sample_t job_a_left_r;
  mau_pkg::sample_t job_a_right_r;
  mau_pkg::sample_t job_b_left_r;
  mau_pkg::sample_t job_b_right_r;
  logic [LGW-1:0]   job_lg_r;
  logic [CW-1:0]    job_cnt_r;

  // output register
  logic             out_valid_r;
  mau_pkg::sample_t out_left_r;
  mau_pkg::sample_t out_right_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_load;
  logic             job_last;
  logic             job_done;
  logic [LGW-1:0]   lg_eff;
  mau_pkg::sample_t new_left;
  mau_pkg::sample_t new_right;
  mau_pkg::sample_t a_left;
  mau_pkg::sample_t a_right;
  mau_pkg::sample_t pt_left;
  mau_pkg::sample_t pt_right;

  mau_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // rate above what the point logic supports saturates
  always_comb begin
    if (int'(cfg.rate_log2) > MAX_RATE_LOG2) begin
      lg_eff = LGW'(MAX_RATE_LOG2);
    end else begin
      lg_eff = LGW'(cfg.rate_log2);
    end
  end

  // mono: left is used for both channels, including the stored start point
  assign new_left  = in_left_in;
  assign new_right = cfg.stereo ? in_right_in : in_left_in;
  // with no previous frame the new frame is its own predecessor
  assign a_left    = have_prev_r ? prev_left_r : new_left;
  assign a_right   = have_prev_r ? (cfg.stereo ? prev_right_r : prev_left_r) : new_right;

  // handshake: the job advances when the output register is free or draining
  assign out_load = job_valid_r && (!out_valid_r || !out_stall);
  assign job_last = (job_cnt_r == CW'((1 << job_lg_r) - 1));
  assign job_done = out_load && job_last;
  assign in_stall = job_valid_r && !job_done;
  assign in_acc   = in_valid && !in_stall;

  mau_point #(.MAX_RATE_LOG2(MAX_RATE_LOG2)) u_pt_left (
    .a       (job_a_left_r),
    .b       (job_b_left_r),
    .lg      (job_lg_r),
    .cnt     (job_cnt_r),
    .is_last (job_last),
    .pt      (pt_left)
  );

  mau_point #(.MAX_RATE_LOG2(MAX_RATE_LOG2)) u_pt_right (
    .a       (job_a_right_r),
    .b       (job_b_right_r),
    .lg      (job_lg_r),
    .cnt     (job_cnt_r),
    .is_last (job_last),
    .pt      (pt_right)
  );

  // previous frame and job control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      job_valid_r  <= 1'b0;
      job_cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        have_prev_r  <= 1'b1;
        prev_left_r  <= new_left;
        prev_right_r <= new_right;
      end
      if (in_acc && !in_prime) begin
        job_valid_r <= 1'b1;
        job_cnt_r   <= '0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (out_load) begin
        job_cnt_r <= job_cnt_r + CW'(1);
      end
    end
  end

  // job payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && !in_prime) begin
      job_a_left_r  <= a_left;
      job_a_right_r <= a_right;
      job_b_left_r  <= new_left;
      job_b_right_r <= new_right;
      job_lg_r      <= lg_eff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= pt_left;
      out_right_r <= pt_right;
      out_last_r  <= job_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;
  assign out_last      = out_last_r;

endmodule

// File: src/mau_cfg_regs.sv
// mau_cfg_regs: apb-style register file for rate_log2 and stereo
// depends on mau_pkg
module mau_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mau_pkg::PADDR_W-1:0]  paddr,
  input  logic [mau_pkg::PDATA_W-1:0]  pwdata,
  output logic [mau_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output mau_pkg::cfg_t                cfg
);

  logic [1:0]        rate_log2_r;
  logic              stereo_r;
  logic              wr_en;
  mau_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = mau_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_log2_r <= mau_pkg::RATE_LOG2_RST;
      stereo_r    <= mau_pkg::STEREO_RST;
    end else if (wr_en) begin
      unique case (idx)
        mau_pkg::REG_RATE_LOG2: rate_log2_r <= pwdata[1:0];
        mau_pkg::REG_STEREO:    stereo_r    <= pwdata[0];
        default:                rate_log2_r <= rate_log2_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mau_pkg::REG_RATE_LOG2: prdata[1:0] = rate_log2_r;
      mau_pkg::REG_STEREO:    prdata[0]   = stereo_r;
      default:                prdata      = '0;
    endcase
  end

  assign cfg.rate_log2 = rate_log2_r;
  assign cfg.stereo    = stereo_r;

endmodule

// File: src/mau_point.sv
// mau_point: one interpolated point by dyadic bisection between two ends
// depends on mau_pkg
module mau_point #(
  parameter int MAX_RATE_LOG2 = 3
) (
  input  mau_pkg::sample_t                      a,
  input  mau_pkg::sample_t                      b,
  input  logic [$clog2(MAX_RATE_LOG2+1)-1:0]    lg,
  input  logic [MAX_RATE_LOG2-1:0]              cnt,
  input  logic                                  is_last,
  output mau_pkg::sample_t                      pt
);

  localparam int JW = MAX_RATE_LOG2 + 1;

  logic [JW-1:0] j;

  assign j = {1'b0, cnt} + JW'(1);

  // walk down the halving tree, stop at the level where j sits on a midpoint
  always_comb begin
    mau_pkg::sample_t lo;
    mau_pkg::sample_t hi;
    mau_pkg::sample_t mid;
    logic             done;
    logic [JW-1:0]    mask;
    logic [JW-1:0]    bitv;
    lo   = a;
    hi   = b;
    pt   = b;
    done = is_last;
    for (int L = MAX_RATE_LOG2 - 1; L >= 0; L--) begin
      mask = JW'((1 << (L + 1)) - 1);
      bitv = JW'(1 << L);
      mid  = mau_pkg::half_sum(lo, hi);
      if (!done && (L < int'(lg))) begin
        if ((j & mask) == bitv) begin
          pt   = mid;
          done = 1'b1;
        end else if (j[L]) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
  end

endmodule

// File: src/mau_checker.sv
// mau_checker: port-level checks for midpoint_audio_upsampler_top, bound in
// below; depends on mau_pkg
module mau_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [15:0]           out_left_out,
  input logic signed [15:0]           out_right_out,
  input logic                         out_last,
  input logic [mau_pkg::PDATA_W-1:0]  prdata,
  input logic                         pready
);

  // reset leaves no frame pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output valid or input stalled right after reset");

  // frames of one run come back to back once the consumer takes them
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("gap inside an output run");

  // a stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_out)
      && $stable(out_right_out) && $stable(out_last)))
    else $error("stalled output frame changed");

  // register port never waits and reads only the implemented bits
  a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pready && (prdata[31:2] == '0))
    else $error("register port not ready or stray read bits");

endmodule

bind midpoint_audio_upsampler_top mau_checker u_mau_checker (.*);

// File: tb/midpoint_audio_upsampler_top_test.sv
// midpoint_audio_upsampler_top_test: self-checking testbench for the midpoint
// audio upsampler; predicts every output frame and compares in order
// depends on mau_pkg and midpoint_audio_upsampler_top
`timescale 1ns / 1ps

module midpoint_audio_upsampler_top_test;

  localparam int MAX_RATE_LOG2  = 3;
  localparam int MAX_RATE       = 1 << MAX_RATE_LOG2;
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES  = 10;   // covers a prime item still in flight
  localparam int DRAIN_LIMIT    = 100000;

  // one predicted output frame
  typedef struct {
    mau_pkg::sample_t left;
    mau_pkg::sample_t right;
    logic             last;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel, all driven from time zero
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_prime = 1'b0;
  mau_pkg::sample_t in_left_in = '0;
  mau_pkg::sample_t in_right_in = '0;

  // result channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  mau_pkg::sample_t out_left_out;
  mau_pkg::sample_t out_right_out;
  logic             out_last;

  // register port
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [mau_pkg::PADDR_W-1:0]  paddr = '0;
  logic [mau_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [mau_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // predictor copy of the registers and of the held previous frame
  logic [1:0]       rate_log2_q = mau_pkg::RATE_LOG2_RST;
  logic             stereo_q = mau_pkg::STEREO_RST;
  mau_pkg::sample_t held_left = '0;
  mau_pkg::sample_t held_right = '0;
  logic             held_valid = 1'b0;

  // frames still owed by the block, oldest first
  frame_t expected_frames[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // hold-off request: the test bumps hold_req, the receiver counts it down
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  midpoint_audio_upsampler_top #(
    .MAX_RATE_LOG2(MAX_RATE_LOG2)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_prime     (in_prime),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // safety net against a hung handshake
  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

  // work out the frames caused by one accepted item and advance the state
  function automatic void predict_frames(logic prime, mau_pkg::sample_t l,
                                         mau_pkg::sample_t r_raw);
    int               lpts[0:MAX_RATE];
    int               rpts[0:MAX_RATE];
    int               lg;
    int               rate;
    int               step;
    int               k;
    mau_pkg::sample_t r;
    frame_t           f;
    lg = (rate_log2_q > MAX_RATE_LOG2) ? MAX_RATE_LOG2 : int'(rate_log2_q);
    rate = 1 << lg;
    // mono takes the left sample for both channels, primes included
    r = stereo_q ? r_raw : l;
    if (prime) begin
      held_left = l;
      held_right = r;
      held_valid = 1'b1;
      return;
    end
    // with nothing held, the frame is its own predecessor
    if (!held_valid) begin
      held_left = l;
      held_right = r;
    end
    lpts[0] = int'(held_left);
    rpts[0] = int'(held_right);
    lpts[rate] = int'(l);
    rpts[rate] = int'(r);
    // repeated halving; int division truncates toward zero
    for (step = rate / 2; step >= 1; step = step / 2) begin
      for (k = step; k < rate; k += 2 * step) begin
        lpts[k] = (lpts[k + step] + lpts[k - step]) / 2;
        rpts[k] = (rpts[k + step] + rpts[k - step]) / 2;
      end
    end
    for (k = 0; k < rate; k++) begin
      f.left = mau_pkg::sample_t'(lpts[k + 1]);
      f.right = stereo_q ? mau_pkg::sample_t'(rpts[k + 1]) : mau_pkg::sample_t'(lpts[k + 1]);
      f.last = (k + 1 == rate);
      expected_frames.push_back(f);
    end
    held_left = l;
    held_right = r;
    held_valid = 1'b1;
  endfunction

  task automatic compare_field(string what, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // receiver: check each accepted frame, then decide the next stall
  always @(posedge clk) begin
    frame_t f;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual %0d/%0d last %0b",
                 $time, out_left_out, out_right_out, out_last);
        mismatch_count++;
      end else begin
        f = expected_frames.pop_front();
        compare_field("left_out", int'(f.left), int'(out_left_out));
        compare_field("right_out", int'(f.right), int'(out_right_out));
        compare_field("last", int'(f.last), int'(out_last));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one item, with random idle cycles first, and wait for acceptance
  task automatic send_item(logic prime, mau_pkg::sample_t l, mau_pkg::sample_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_prime <= prime;
    in_left_in <= l;
    in_right_in <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frames(prime, l, r);
  endtask

  // stop offering and wait until every owed frame has come, plus a margin
  task automatic wait_idle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_frames.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_frames.size() != 0) begin
      $display("%0t: %0d frames never came, expected %0d/%0d, actual none",
               $time, expected_frames.size(), expected_frames[0].left,
               expected_frames[0].right);
      mismatch_count++;
      expected_frames.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle; written at the access edge
  task automatic write_register(mau_pkg::reg_idx_t idx, logic [mau_pkg::PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == mau_pkg::REG_RATE_LOG2) rate_log2_q = value[1:0];
    else stereo_q = value[0];
  endtask

  // block must be idle; upper bits carry junk that the block has to ignore
  task automatic set_mode(logic [1:0] rate_log2, logic stereo);
    write_register(mau_pkg::REG_RATE_LOG2, {30'($urandom), rate_log2});
    write_register(mau_pkg::REG_STEREO, {$urandom_range(1) ? 31'h7fff_fff0 : 31'd0, stereo});
  endtask

  function automatic mau_pkg::sample_t rand_sample();
    unique case ($urandom_range(9))
      0: return mau_pkg::sample_t'(16'sh7fff);
      1: return mau_pkg::sample_t'(16'sh8000);
      2: return mau_pkg::sample_t'($urandom_range(8)) - mau_pkg::sample_t'(4);
      default: return mau_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      send_item($urandom_range(99) < 8, rand_sample(), rand_sample());
    end
  endtask

  // right after reset: stereo default, x8, first frame is its own predecessor
  task automatic test_first_frame();
    write_register(mau_pkg::REG_RATE_LOG2, 32'd3);
    send_item(1'b0, 16'sd1234, -16'sd4321);
    send_item(1'b0, -16'sd1234, 16'sd4321);
    wait_idle();
  endtask

  // extremes, truncation of odd negative sums and an all-zero frame
  task automatic test_extremes_rounding();
    send_item(1'b0, 16'sh7fff, 16'sh8000);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    send_item(1'b0, -16'sd3, -16'sd4);
    send_item(1'b0, -16'sd4, -16'sd3);
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sh7fff, 16'sh7fff);
    send_item(1'b0, 16'sh8000, 16'sh8000);
    wait_idle();
  endtask

  // mono at x4: right input ignored, a prime loads left into both channels
  task automatic test_mono_prime();
    set_mode(2'd2, 1'b0);
    send_item(1'b1, 16'sd100, 16'sd9999);
    send_item(1'b0, -16'sd101, 16'sd5555);
    send_item(1'b1, 16'sh8000, 16'sh7fff);
    send_item(1'b0, 16'sh7fff, 16'sd0);
    send_item(1'b0, -16'sd7, 16'sd1);
    wait_idle();
  endtask

  // stereo at x1 and x2 with primes in between
  task automatic test_low_rates();
    set_mode(2'd0, 1'b1);
    send_item(1'b1, 16'sd5, 16'sd6);
    send_item(1'b0, 16'sd7, -16'sd8);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    wait_idle();
    set_mode(2'd1, 1'b1);
    send_item(1'b0, -16'sd1, 16'sd1);
    send_item(1'b1, 16'sh7fff, 16'sh8000);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    wait_idle();
  endtask

  // random content in chunks, each chunk under a fresh register setting
  task automatic test_random_settings(int chunks, int per_chunk);
    repeat (chunks) begin
      set_mode(2'($urandom_range(3)), 1'($urandom_range(1)));
      send_random(per_chunk);
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_holdoff();
    set_mode(2'd3, 1'b1);
    hold_req <= hold_req + 1;
    send_random(30);
    wait_idle();
  endtask

  // sender stops until every owed frame is out, then carries on
  task automatic test_sender_pause();
    set_mode(2'd3, 1'b0);
    send_random(10);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    send_random(10);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 33;
    recv_idle_pct = 84;
    test_first_frame();
    test_extremes_rounding();
    test_mono_prime();
    test_low_rates();
    test_random_settings(4, 30);

    // the other way round
    send_idle_pct = 84;
    recv_idle_pct = 33;
    test_random_settings(4, 30);
    test_output_holdoff();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(4, 30);
    test_sender_pause();

    // final drain already done in the last test; allow stray frames to show
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mau_pkg.sv
src/mau_cfg_regs.sv
src/mau_point.sv
src/midpoint_audio_upsampler_top.sv
src/mau_checker.sv
tb/midpoint_audio_upsampler_top_test.sv
